>>> rtl/spq_pkg.sv
// shared types and constants for the sorted priority queue
// no dependencies; used by rtl/sorted_priority_queue.sv and tb/tb_sorted_priority_queue.sv
`default_nettype none

package spq_pkg;

  localparam int unsigned CAPACITY = 128;
  localparam int unsigned ADDR_W   = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned TOTAL_W  = 8;
  localparam int unsigned OUT_W    = 48;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_DELETE = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_MISSING = 2'd3
  } status_e;

endpackage

`default_nettype wire

>>> rtl/sorted_priority_queue.sv
// Sorted priority queue: up to spq_pkg::CAPACITY signed 32-bit values kept in descending
// order in one single-port-read synchronous memory. An insert is placed before the first
// stored value less than or equal to it; a delete removes the first entry equal to its
// value. Every request returns one transaction with the top value, the entry count, an
// empty flag and a status (ok, insert dropped full, delete on empty, value not found).
// One request is worked on at a time, walking the memory one entry per cycle with a
// read-modify-write of neighboring entries. An insert walks from the bottom entry up to
// its position, a delete walks every stored entry; an insert into an empty queue, a
// dropped insert or a delete on an empty queue needs no walk. Each result is then posted
// from S_FIN. A result waiting on m_axis does not stop the next request from being taken.
// The memory needs no clearing after reset.
// depends on rtl/spq_pkg.sv
`default_nettype none

module sorted_priority_queue (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [31:0] value
  input  wire logic [0:0]  s_axis_tuser,   // [0] req_type
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata    // [31:0] top_value, [39:32] entry_total,
                                           // [40] is_empty, [42:41] status, [47:43] zero
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_INS  = 5'b00010,
    S_IWR0 = 5'b00100,
    S_DEL  = 5'b01000,
    S_FIN  = 5'b10000
  } state_e;

  localparam logic [spq_pkg::CNT_W-1:0] CapCount = spq_pkg::CNT_W'(spq_pkg::CAPACITY);

  state_e state_q, state_d;
  logic [spq_pkg::ADDR_W-1:0] k_q, k_d;
  logic found_q, found_d;
  logic [spq_pkg::CNT_W-1:0] count_q, count_d;
  logic signed [spq_pkg::VAL_W-1:0] top_q, top_d;
  logic signed [spq_pkg::VAL_W-1:0] val_q, val_d;
  spq_pkg::status_e status_q, status_d;
  logic m_valid_q, m_valid_d;
  logic [spq_pkg::OUT_W-1:0] m_data_q, m_data_d;

  logic signed [spq_pkg::VAL_W-1:0] mem [spq_pkg::CAPACITY];
  logic signed [spq_pkg::VAL_W-1:0] rd_data_q;
  logic [spq_pkg::ADDR_W-1:0] rd_addr;
  logic we;
  logic [spq_pkg::ADDR_W-1:0] wa;
  logic signed [spq_pkg::VAL_W-1:0] wd;

  logic accept;
  logic hit;
  logic found_now;
  logic last_entry;
  logic out_free;
  logic signed [spq_pkg::VAL_W-1:0] top_out;

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign hit           = !found_q && (rd_data_q == val_q);
  assign found_now     = found_q || hit;
  assign last_entry    = (spq_pkg::CNT_W'(k_q) == (count_q - spq_pkg::CNT_W'(1)));
  assign top_out       = (count_q == '0) ? '0 : top_q;

  always_comb begin
    state_d   = state_q;
    k_d       = k_q;
    found_d   = found_q;
    count_d   = count_q;
    top_d     = top_q;
    val_d     = val_q;
    status_d  = status_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    m_data_d  = m_data_q;
    rd_addr   = '0;
    we        = 1'b0;
    wa        = '0;
    wd        = val_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          val_d = s_axis_tdata;
          if (s_axis_tuser[0] == spq_pkg::REQ_INSERT) begin
            if (count_q == CapCount) begin
              status_d = spq_pkg::ST_FULL;
              state_d  = S_FIN;
            end else if (count_q == '0) begin
              we       = 1'b1;
              wa       = '0;
              wd       = s_axis_tdata;
              count_d  = spq_pkg::CNT_W'(1);
              status_d = spq_pkg::ST_OK;
              state_d  = S_FIN;
            end else begin
              // walk upward from the bottom entry
              rd_addr = spq_pkg::ADDR_W'(count_q - spq_pkg::CNT_W'(1));
              k_d     = spq_pkg::ADDR_W'(count_q - spq_pkg::CNT_W'(1));
              state_d = S_INS;
            end
          end else begin
            if (count_q == '0) begin
              status_d = spq_pkg::ST_EMPTY;
              state_d  = S_FIN;
            end else begin
              rd_addr = '0;
              k_d     = '0;
              found_d = 1'b0;
              state_d = S_DEL;
            end
          end
        end
      end
      S_INS: begin
        we = 1'b1;
        wa = k_q + spq_pkg::ADDR_W'(1);
        if (val_q >= rd_data_q) begin
          // entry moves down one place
          wd = rd_data_q;
          if (k_q == '0) begin
            state_d = S_IWR0;
          end else begin
            k_d     = k_q - spq_pkg::ADDR_W'(1);
            rd_addr = k_q - spq_pkg::ADDR_W'(1);
          end
        end else begin
          wd       = val_q;
          count_d  = count_q + spq_pkg::CNT_W'(1);
          status_d = spq_pkg::ST_OK;
          state_d  = S_FIN;
        end
      end
      S_IWR0: begin
        we       = 1'b1;
        wa       = '0;
        wd       = val_q;
        count_d  = count_q + spq_pkg::CNT_W'(1);
        status_d = spq_pkg::ST_OK;
        state_d  = S_FIN;
      end
      S_DEL: begin
        // once the match is found every later entry moves up one place
        if (found_q) begin
          we = 1'b1;
          wa = k_q - spq_pkg::ADDR_W'(1);
          wd = rd_data_q;
        end
        found_d = found_now;
        if (last_entry) begin
          if (found_now) begin
            count_d  = count_q - spq_pkg::CNT_W'(1);
            status_d = spq_pkg::ST_OK;
          end else begin
            status_d = spq_pkg::ST_MISSING;
          end
          state_d = S_FIN;
        end else begin
          k_d     = k_q + spq_pkg::ADDR_W'(1);
          rd_addr = k_q + spq_pkg::ADDR_W'(1);
        end
      end
      S_FIN: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_data_d  = {5'b0, status_q, (count_q == '0),
                       spq_pkg::TOTAL_W'(count_q), top_out};
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // shadow copy of the head entry
    if (we && (wa == '0)) begin
      top_d = wd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      m_valid_q <= 1'b0;
      found_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      m_valid_q <= m_valid_d;
      found_q   <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q      <= k_d;
    top_q    <= top_d;
    val_q    <= val_d;
    status_q <= status_d;
    m_data_q <= m_data_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CapCount)
    else $error("entry count above capacity");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INS) |-> (count_q != CapCount))
    else $error("insert walk started on a full queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN) && out_free && (status_q != spq_pkg::ST_OK)
      |=> $stable(count_q))
    else $error("failed request changed the entry count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DEL) && found_q |-> (k_q != '0))
    else $error("delete shift below the head entry");

endmodule

`default_nettype wire

>>> tb/tb_sorted_priority_queue.sv
// self-checking testbench for sorted_priority_queue: directed and random insert/delete
// traffic predicted by a behavioral sorted array; depends on rtl/spq_pkg.sv and block rtl
`timescale 1ns / 100ps

module tb_sorted_priority_queue;

  localparam int ITEM_TARGET = 1100;
  localparam int IDLE_LIMIT  = 4000;
  localparam int DRAIN_WAIT  = 300;
  localparam int MAX_SHOWN   = 10;

  localparam logic [31:0] VAL_MAX = 32'h7fff_ffff;
  localparam logic [31:0] VAL_MIN = 32'h8000_0000;

  typedef struct packed {
    spq_pkg::req_e op;
    logic [31:0]   val;
  } req_t;

  typedef struct packed {
    logic [31:0]      top;
    logic [7:0]       total;
    logic             empty;
    spq_pkg::status_e status;
  } qresult_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [0:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;

  sorted_priority_queue u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  wire req_fire = s_axis_tvalid & s_axis_tready;
  wire res_fire = m_axis_tvalid & m_axis_tready;

  // request stream and the results it should produce
  req_t        req_q[$];
  qresult_t    result_q[$];
  logic [31:0] live_values[$];   // multiset the generator believes is stored
  int          gen_total = 0;

  // shadow of the queue contents, descending
  logic signed [31:0] shadow_mem [spq_pkg::CAPACITY];
  int unsigned        shadow_cnt = 0;

  int n_insert = 0, n_delete = 0, n_full = 0, n_empty_del = 0, n_missing = 0;
  int peak_cnt = 0, n_checked = 0, err_cnt = 0;

  function automatic qresult_t apply_request(req_t r);
    qresult_t           res;
    spq_pkg::status_e   st;
    int unsigned        pos;
    logic signed [31:0] v;
    v = r.val;
    pos = 0;
    if (r.op == spq_pkg::REQ_INSERT) begin
      n_insert++;
      if (shadow_cnt >= spq_pkg::CAPACITY) begin
        st = spq_pkg::ST_FULL;
        n_full++;
      end else begin
        // goes ahead of the first entry less than or equal to it
        while (pos < shadow_cnt && !(v >= shadow_mem[pos])) pos++;
        for (int unsigned k = shadow_cnt; k > pos; k--) shadow_mem[k] = shadow_mem[k-1];
        shadow_mem[pos] = v;
        shadow_cnt++;
        st = spq_pkg::ST_OK;
      end
    end else begin
      n_delete++;
      if (shadow_cnt == 0) begin
        st = spq_pkg::ST_EMPTY;
        n_empty_del++;
      end else begin
        while (pos < shadow_cnt && shadow_mem[pos] != v) pos++;
        if (pos >= shadow_cnt) begin
          st = spq_pkg::ST_MISSING;
          n_missing++;
        end else begin
          for (int unsigned k = pos; k + 1 < shadow_cnt; k++) shadow_mem[k] = shadow_mem[k+1];
          shadow_cnt--;
          st = spq_pkg::ST_OK;
        end
      end
    end
    if (shadow_cnt > peak_cnt) peak_cnt = shadow_cnt;
    res.top    = (shadow_cnt > 0) ? shadow_mem[0] : '0;
    res.total  = 8'(shadow_cnt);
    res.empty  = (shadow_cnt == 0);
    res.status = st;
    return res;
  endfunction

  function automatic void flag_error(string msg);
    err_cnt++;
    if (err_cnt <= MAX_SHOWN) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  function automatic void check_result(logic [47:0] d);
    qresult_t want;
    n_checked++;
    if (result_q.size() == 0) begin
      flag_error($sformatf("result with nothing outstanding, tdata=%h", d));
      return;
    end
    want = result_q.pop_front();
    if (d[31:0] !== want.top || d[39:32] !== want.total || d[40] !== want.empty ||
        d[42:41] !== want.status || d[47:43] !== 5'd0)
      flag_error($sformatf(
        "result %0d: exp top %0d total %0d empty %0b status %s, got top %0d total %0d empty %0b status %0d pad %0h",
        n_checked, $signed(want.top), want.total, want.empty, want.status.name(),
        $signed(d[31:0]), d[39:32], d[40], d[42:41], d[47:43]));
  endfunction

  // queue a request and keep the generator's view of the contents current
  function automatic void push_request(spq_pkg::req_e op, logic [31:0] v);
    int idx;
    idx = -1;
    req_q.push_back('{op: op, val: v});
    gen_total++;
    if (op == spq_pkg::REQ_INSERT) begin
      if (live_values.size() < spq_pkg::CAPACITY) live_values.push_back(v);
    end else begin
      foreach (live_values[i]) if (idx < 0 && live_values[i] == v) idx = i;
      if (idx >= 0) live_values.delete(idx);
    end
  endfunction

  // small range for duplicates, full range for bit coverage, some extremes
  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 32'($urandom_range(0, 16)) - 32'd8;
    if (r < 90) return $urandom;
    case ($urandom_range(0, 3))
      0:       return VAL_MAX;
      1:       return VAL_MIN;
      2:       return 32'hffff_ffff;
      default: return 32'd0;
    endcase
  endfunction

  function automatic logic [31:0] pick_live();
    return live_values[$urandom_range(0, live_values.size() - 1)];
  endfunction

  function automatic int gap_len(bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // request driver
  bit src_quiet = 1'b0;
  int src_gap = 0;
  req_t next_req;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (req_fire) begin
        result_q.push_back(apply_request('{op: spq_pkg::req_e'(s_axis_tuser[0]),
                                           val: s_axis_tdata}));
        if ($urandom_range(0, 47) == 0) src_quiet = !src_quiet;
      end
      if (s_axis_tvalid && !req_fire) begin
        // hold the pending transaction
      end else if (src_gap > 0) begin
        src_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (req_q.size() > 0) begin
        next_req = req_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= next_req.val;
        s_axis_tuser  <= next_req.op;
        src_gap = gap_len(src_quiet);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result monitor with random backpressure
  bit snk_quiet = 1'b0;
  int snk_stall = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (res_fire) begin
        check_result(m_axis_tdata);
        if ($urandom_range(0, 47) == 0) snk_quiet = !snk_quiet;
      end
      if (snk_stall > 0) snk_stall--;
      else if (res_fire || (!m_axis_tvalid && $urandom_range(0, 15) == 0))
        snk_stall = gap_len(snk_quiet);
      m_axis_tready <= (snk_stall == 0);
    end
  end

  // watchdog on cycles with no transaction on either side
  int idle_cycles = 0;

  always @(posedge clk_i) begin
    if (req_fire || res_fire) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("ERROR: no transaction for %0d cycles, %0d results outstanding",
               idle_cycles, result_q.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int phase;
    int n;
    int r;
    phase = 0;

    // directed: empty delete, extremes, equal values, missing value, top and bottom removal
    push_request(spq_pkg::REQ_DELETE, 32'd3);
    push_request(spq_pkg::REQ_INSERT, 32'd0);
    push_request(spq_pkg::REQ_INSERT, VAL_MAX);
    push_request(spq_pkg::REQ_INSERT, VAL_MIN);
    push_request(spq_pkg::REQ_INSERT, 32'hffff_ffff);
    push_request(spq_pkg::REQ_INSERT, 32'd5);
    push_request(spq_pkg::REQ_INSERT, 32'd5);
    push_request(spq_pkg::REQ_INSERT, 32'hffff_ffff);
    push_request(spq_pkg::REQ_DELETE, 32'd42);
    push_request(spq_pkg::REQ_DELETE, 32'd5);
    push_request(spq_pkg::REQ_DELETE, VAL_MAX);
    push_request(spq_pkg::REQ_DELETE, VAL_MIN);
    push_request(spq_pkg::REQ_DELETE, 32'hffff_ffff);
    push_request(spq_pkg::REQ_DELETE, 32'hffff_ffff);
    push_request(spq_pkg::REQ_DELETE, 32'd0);
    push_request(spq_pkg::REQ_DELETE, 32'd5);
    push_request(spq_pkg::REQ_DELETE, 32'd5);
    push_request(spq_pkg::REQ_INSERT, 32'h5555_5555);
    push_request(spq_pkg::REQ_INSERT, 32'haaaa_aaaa);
    push_request(spq_pkg::REQ_DELETE, 32'h5555_5555);
    push_request(spq_pkg::REQ_DELETE, 32'haaaa_aaaa);

    // random: fill past capacity, churn, then drain past empty
    while (gen_total < ITEM_TARGET) begin
      case (phase % 3)
        0: begin
          n = spq_pkg::CAPACITY - live_values.size() + $urandom_range(8, 24);
          repeat (n) begin
            if (live_values.size() > 0 && $urandom_range(0, 9) == 0)
              push_request(spq_pkg::REQ_DELETE, pick_live());
            else
              push_request(spq_pkg::REQ_INSERT, pick_value());
          end
        end
        1: begin
          repeat (100) begin
            r = $urandom_range(0, 99);
            if (r < 45) push_request(spq_pkg::REQ_INSERT, pick_value());
            else if (r < 85 && live_values.size() > 0)
              push_request(spq_pkg::REQ_DELETE, pick_live());
            else push_request(spq_pkg::REQ_DELETE, pick_value());
          end
        end
        default: begin
          while (live_values.size() > 0) begin
            if ($urandom_range(0, 9) == 0) push_request(spq_pkg::REQ_DELETE, pick_value());
            else push_request(spq_pkg::REQ_DELETE, pick_live());
          end
          repeat ($urandom_range(2, 5)) push_request(spq_pkg::REQ_DELETE, pick_value());
        end
      endcase
      phase++;
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i);
    while (req_q.size() > 0 || s_axis_tvalid || result_q.size() > 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (result_q.size() > 0)
      flag_error($sformatf("%0d results never arrived", result_q.size()));

    $display("ran %0d requests: %0d inserts (%0d dropped full), %0d deletes", gen_total,
             n_insert, n_full, n_delete);
    $display("%0d deletes on empty, %0d misses, peak fill %0d of %0d, %0d results checked",
             n_empty_del, n_missing, peak_cnt, spq_pkg::CAPACITY, n_checked);
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
